// ===== hdl/lkv_pkg.sv =====
// Package: sizes and operation codes of the LRU key/value cache.
package lkv_pkg;
  localparam int ENTRIES    = 128;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int CNT_BITS   = IDX_BITS + 1;
  localparam int RANK_BITS  = IDX_BITS;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [RANK_BITS-1:0]  rank_t;
endpackage

// ===== hdl/lkv_if.sv =====
// Interfaces: request and response channels of the LRU key/value cache.
interface lkv_req_if;
  logic                   valid;
  logic                   ready;
  logic [1:0]             kind;
  logic [lkv_pkg::KEY_BITS-1:0]   key;
  logic [lkv_pkg::VALUE_BITS-1:0] value_in;
  modport source (output valid, kind, key, value_in, input ready);
  modport sink   (input valid, kind, key, value_in, output ready);
endinterface

interface lkv_rsp_if;
  logic                   valid;
  logic                   ready;
  logic                   hit;
  logic [lkv_pkg::VALUE_BITS-1:0] value_out;
  logic                   evicted;
  logic [lkv_pkg::KEY_BITS-1:0]   evicted_key;
  logic [lkv_pkg::CNT_BITS-1:0]   occupancy;
  modport source (output valid, hit, value_out, evicted, evicted_key, occupancy,
                  input ready);
  modport sink   (input valid, hit, value_out, evicted, evicted_key, occupancy,
                  output ready);
endinterface

// ===== hdl/lkv_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module lkv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== hdl/lru_key_value_cache_top.sv =====
// Top level: fully associative LRU key/value cache with a sequencer over RAMs.
//
// One request is handled at a time. Keys, values and recency ranks live in
// three single-read RAMs; valid bits and the entry count sit in flops. A
// lookup or insert first scans all ENTRIES slots to find the key, the oldest
// entry (rank count-1) and the first free slot. A lookup hit or an absent-key
// insert then makes a second read-modify-write pass over the rank RAM. The
// response sits in an output register, so a new request is taken while the
// previous response still waits; the finish step of that next request stalls
// until the waiting response is taken. The capacity register may be written
// only while idle; 0 acts as 1 and values above ENTRIES act as ENTRIES.
module lru_key_value_cache_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  lkv_req_if.sink                req,
  lkv_rsp_if.source              rsp
);
  import lkv_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [2:0]         state;
  logic [7:0]         capacity;
  logic [ENTRIES-1:0] vld;
  cnt_t               count;

  // latched request
  logic [1:0] kind_r;
  key_t       key_r;
  value_t     val_r;

  // pass counter and read pipe
  cnt_t  scan_addr;
  logic  rd_vld;
  idx_t  rd_idx;

  // scan findings
  logic  found;
  idx_t  slot;
  rank_t r_rank;
  idx_t  oldest;
  key_t  oldest_key;
  logic  free_found;
  idx_t  free_idx;

  // pending response
  logic   res_hit, res_ev, vrd;
  value_t res_vout;
  key_t   res_evkey;

  // RAM ports
  key_t   key_q;
  value_t value_q;
  rank_t  rank_q, rank_wdata;
  logic   rd_en, rank_we, kv_we, val_re;

  logic   pass_end, evict_now, cur_vld;
  cnt_t   eff_cap;
  idx_t   ins_slot;

  assign rd_en     = (state == S_SCAN || state == S_UPD) && (scan_addr != cnt_t'(ENTRIES));
  assign pass_end  = (scan_addr == cnt_t'(ENTRIES)) && !rd_vld;
  assign cur_vld   = vld[rd_idx];
  assign rank_we   = (state == S_UPD) && rd_vld;
  assign kv_we     = (state == S_UPD) && pass_end && (kind_r == OP_INSERT);
  assign val_re    = (state == S_SCAN) && pass_end && (kind_r == OP_LOOKUP) && found;

  assign eff_cap = (capacity == 8'd0) ? cnt_t'(1) :
                   ({1'b0, capacity} > 9'(ENTRIES)) ? cnt_t'(ENTRIES) : cnt_t'(capacity);
  assign evict_now = (count >= eff_cap) && (count != '0);
  // insert slot: lowest invalid index, or after an eviction the lower of that and the evicted slot
  assign ins_slot  = !evict_now ? free_idx :
                     (free_found && free_idx < oldest) ? free_idx : oldest;

  // Rank update: the touched slot becomes most recent; others age (on a lookup only the more recent ones).
  always_comb begin
    rank_wdata = rank_q;
    if (rd_idx == slot) begin
      rank_wdata = '0;
    end else if (kind_r == OP_LOOKUP) begin
      if (cur_vld && rank_q < r_rank) rank_wdata = rank_q + rank_t'(1);
    end else if (cur_vld) begin
      rank_wdata = rank_q + rank_t'(1);
    end
  end

  lkv_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk(clk), .we(kv_we), .waddr(slot), .wdata(key_r),
    .re(rd_en), .raddr(scan_addr[IDX_BITS-1:0]), .rdata(key_q)
  );

  lkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_value_ram (
    .clk(clk), .we(kv_we), .waddr(slot), .wdata(val_r),
    .re(val_re), .raddr(slot), .rdata(value_q)
  );

  lkv_ram #(.WIDTH(RANK_BITS), .DEPTH(ENTRIES)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(rd_idx), .wdata(rank_wdata),
    .re(rd_en), .raddr(scan_addr[IDX_BITS-1:0]), .rdata(rank_q)
  );

  assign req.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= 8'd128;
      vld       <= '0;
      count     <= '0;
      rd_vld    <= 1'b0;
      vrd       <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_wdata;
      // the finish step reloads the response register itself
      if (rsp.valid && rsp.ready && state != S_FIN) rsp.valid <= 1'b0;

      rd_vld <= rd_en;
      rd_idx <= scan_addr[IDX_BITS-1:0];
      if (rd_en) scan_addr <= scan_addr + cnt_t'(1);

      vrd <= val_re;
      if (vrd) res_vout <= value_q;

      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            kind_r     <= req.kind;
            key_r      <= req.key;
            val_r      <= req.value_in;
            scan_addr  <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            res_hit    <= 1'b0;
            res_ev     <= 1'b0;
            res_vout   <= '0;
            res_evkey  <= '0;
            if (req.kind == OP_LOOKUP || req.kind == OP_INSERT) begin
              state <= S_SCAN;
            end else begin
              if (req.kind == OP_CLEAR) begin
                vld   <= '0;
                count <= '0;
              end
              state <= S_FIN;
            end
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (cur_vld && key_q == key_r && !found) begin
              found  <= 1'b1;
              slot   <= rd_idx;
              r_rank <= rank_q;
            end
            if (cur_vld && {1'b0, rank_q} == count - cnt_t'(1)) begin
              oldest     <= rd_idx;
              oldest_key <= key_q;
            end
            if (!cur_vld && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= rd_idx;
            end
          end
          if (pass_end) begin
            scan_addr <= '0;
            if (found) begin
              res_hit <= 1'b1;
              state   <= (kind_r == OP_LOOKUP) ? S_UPD : S_FIN;
            end else if (kind_r == OP_LOOKUP) begin
              state <= S_FIN;
            end else begin
              if (evict_now) begin
                vld[oldest] <= 1'b0;
                count       <= count - cnt_t'(1);
                res_ev      <= 1'b1;
                res_evkey   <= oldest_key;
              end
              slot  <= ins_slot;
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (pass_end) begin
            if (kind_r == OP_INSERT) begin
              vld[slot] <= 1'b1;
              count     <= count + cnt_t'(1);
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid       <= 1'b1;
            rsp.hit         <= res_hit;
            rsp.value_out   <= res_vout;
            rsp.evicted     <= res_ev;
            rsp.evicted_key <= res_evkey;
            rsp.occupancy   <= count;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== bench/tb_lru_key_value_cache_top.sv =====
// Testbench: randomized check of the LRU key/value cache against a behavioral predictor.

class lru_scoreboard;
  typedef struct packed {
    logic                   hit;
    logic [31:0]            value_out;
    logic                   evicted;
    logic [31:0]            evicted_key;
    logic [lkv_pkg::CNT_BITS-1:0] occupancy;
  } result_t;

  // predictor state
  bit [31:0] keys[lkv_pkg::ENTRIES];
  bit [31:0] vals[lkv_pkg::ENTRIES];
  bit        used[lkv_pkg::ENTRIES];
  int        rank[lkv_pkg::ENTRIES];
  int        count;
  int        capacity;
  result_t   pending[$];
  int        mismatches;

  function new();
    foreach (used[i]) used[i] = 0;
    count = 0;
    capacity = 128;
    mismatches = 0;
  endfunction

  function void set_capacity(bit [7:0] c);
    capacity = int'(c);
  endfunction

  function int find_slot(bit [31:0] k);
    foreach (used[i]) if (used[i] && keys[i] == k) return i;
    return -1;
  endfunction

  // predict the response for one accepted request
  function void note_request(logic [1:0] kind, bit [31:0] k, bit [31:0] v);
    result_t r;
    int s, cap, old, best;
    r = '0;
    cap = (capacity == 0) ? 1 : (capacity > lkv_pkg::ENTRIES ? lkv_pkg::ENTRIES : capacity);
    if (kind == lkv_pkg::OP_LOOKUP) begin
      s = find_slot(k);
      if (s >= 0) begin
        foreach (used[i]) if (used[i] && rank[i] < rank[s]) rank[i]++;
        rank[s] = 0;
        r.hit = 1'b1;
        r.value_out = vals[s];
      end
    end else if (kind == lkv_pkg::OP_INSERT) begin
      s = find_slot(k);
      if (s >= 0) r.hit = 1'b1;
      else begin
        if (count >= cap && count > 0) begin
          old = -1;
          best = 0;
          foreach (used[i])
            if (used[i] && (old < 0 || rank[i] > best)) begin
              old = i;
              best = rank[i];
            end
          used[old] = 0;
          count--;
          r.evicted = 1'b1;
          r.evicted_key = keys[old];
        end
        s = -1;
        foreach (used[i]) if (!used[i] && s < 0) s = i;
        if (s >= 0) begin
          foreach (used[i]) if (used[i]) rank[i]++;
          keys[s] = k;
          vals[s] = v;
          rank[s] = 0;
          used[s] = 1;
          count++;
        end
      end
    end else if (kind == lkv_pkg::OP_CLEAR) begin
      foreach (used[i]) used[i] = 0;
      count = 0;
    end
    r.occupancy = lkv_pkg::CNT_BITS'(count);
    pending.push_back(r);
  endfunction

  function void check_response(result_t got);
    result_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected response %p", got);
      return;
    end
    exp = pending.pop_front();
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
    end
  endfunction
endclass

module tb_lru_key_value_cache_top;
  import lkv_pkg::*;

  localparam int IDLE_LIMIT = 20000;   // cycles with no handshake before giving up
  localparam int DRAIN_CYCLES = 2 * ENTRIES + 10;
  localparam logic [1:0] OP_UNUSED = 2'd3;   // kind with no operation

  logic       clk = 0;
  logic       rst = 1;
  logic       cfg_we = 0;
  logic [7:0] cfg_wdata = '0;

  lkv_req_if req();
  lkv_rsp_if rsp();

  lru_key_value_cache_top dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  always #5 clk = ~clk;

  lru_scoreboard board = new();
  int  idle_cycles = 0;
  bit  hold_off = 0;        // receiver holds ready low for a long stretch
  bit  stall_enable = 1;
  bit [31:0] key_pool[8];   // small key set so hits and evictions are common

  // gap length: mostly short, sometimes long
  function automatic int pick_gap();
    int p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3);
    return $urandom_range(300, 40);
  endfunction

  // Accept check: every request handshake feeds the predictor, every response
  // handshake is compared; both sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) board.note_request(req.kind, req.key, req.value_in);
      if (rsp.valid && rsp.ready)
        board.check_response({rsp.hit, rsp.value_out, rsp.evicted, rsp.evicted_key,
                              rsp.occupancy});
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Receiver: random ready with gaps, or held low during a hold-off.
  initial begin : receiver
    int gap;
    rsp.ready <= 0;
    @(negedge rst);
    forever begin
      gap = (hold_off || !stall_enable) ? 0 : pick_gap();
      if (hold_off) begin
        rsp.ready <= 0;
        repeat (3 * ENTRIES * 3) @(posedge clk);
        hold_off = 0;
      end
      if (gap > 0) begin
        rsp.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1;
      @(posedge clk);
    end
  end

  // Drive one request and wait for its handshake; gaps are taken beforehand.
  task automatic send_request(logic [1:0] kind, bit [31:0] k, bit [31:0] v);
    int gap;
    gap = stall_enable ? pick_gap() : 0;
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1;
    req.kind <= kind;
    req.key <= k;
    req.value_in <= v;
    do @(posedge clk); while (!req.ready);
  endtask

  // drop valid first so the monitor has seen the last accepted request before the queue is polled
  task automatic wait_drained();
    req.valid <= 0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(bit [7:0] c);
    wait_drained();
    cfg_we <= 1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 0;
    board.set_capacity(c);
  endtask

  // Random requests biased toward a small key pool; the unused kind is noise.
  task automatic random_requests(int n);
    int p;
    logic [1:0] kind;
    bit [31:0] k;
    repeat (n) begin
      p = $urandom_range(99);
      kind = (p < 40) ? OP_LOOKUP : (p < 92) ? OP_INSERT : (p < 96) ? OP_CLEAR : OP_UNUSED;
      k = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom;
      send_request(kind, k, $urandom);
    end
  endtask

  initial begin : stimulus
    req.valid <= 0;
    req.kind <= OP_LOOKUP;
    req.key <= '0;
    req.value_in <= '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes of key and value, every operation, unused kind.
    write_capacity(8'd2);
    send_request(OP_LOOKUP, 32'h0, 32'h0);          // miss on empty store
    send_request(OP_INSERT, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_INSERT, 32'h0, 32'h1234_5678);  // present: ignored
    send_request(OP_LOOKUP, 32'h0, 32'h0);          // hit, becomes most recent
    send_request(OP_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5); // evicts all-ones key
    send_request(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_CLEAR, 32'h0, 32'h0);
    send_request(OP_LOOKUP, 32'h0, 32'h0);
    // capacity 0 acts as one entry
    write_capacity(8'd0);
    send_request(OP_INSERT, 32'h1, 32'h2);
    send_request(OP_INSERT, 32'h3, 32'h4);
    // fill to capacity 6, then lower capacity below occupancy: one eviction per insert
    write_capacity(8'd6);
    foreach (key_pool[i]) send_request(OP_INSERT, key_pool[i], $urandom);
    write_capacity(8'd3);
    send_request(OP_INSERT, 32'h7777_0000, 32'h1);
    send_request(OP_INSERT, 32'h7777_0001, 32'h2);
    send_request(OP_LOOKUP, key_pool[7], 32'h0);

    // Random phases over several capacities, extremes included.
    write_capacity(8'd4);
    random_requests(80);
    // receiver holds off, so requests back up behind a waiting response
    hold_off = 1;
    random_requests(20);
    write_capacity(8'd255);
    random_requests(60);
    write_capacity(8'd128);
    for (int i = 0; i < 130; i++) send_request(OP_INSERT, $urandom, $urandom);
    random_requests(20);
    write_capacity(8'd1);
    random_requests(40);
    // back-to-back stretch with no idling
    stall_enable = 0;
    write_capacity(8'd7);
    random_requests(50);
    stall_enable = 1;
    random_requests(20);

    wait_drained();
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
